// ===== rtl/gaps_pkg.sv =====
package gaps_pkg;

  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;

  localparam int COST_W  = 28;
  localparam int COORD_W = 6;
  localparam int STEP_W  = 12;
  localparam int LEN_W   = 13;
  localparam int STR_W   = 10;
  localparam int DIAG_W  = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] COST_CAP = 28'h0fffffff;

  localparam logic             EIGHT_WAY_RST = 1'b1;
  localparam logic [STR_W-1:0]  STRAIGHT_RST  = 10'd16;
  localparam logic [DIAG_W-1:0] DIAGONAL_RST  = 11'd22;

  // Move directions 0..7 in raster order around the current cell.
  localparam logic [7:0] DX_NEG = 8'b0010_1001;
  localparam logic [7:0] DX_POS = 8'b1001_0100;
  localparam logic [7:0] DY_NEG = 8'b0000_0111;
  localparam logic [7:0] DY_POS = 8'b1110_0000;
  localparam logic [7:0] DIAG   = 8'b1010_0101;

  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd6;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2
  } gaps_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EIGHT_WAY = 2'd0,
    CFG_STRAIGHT  = 2'd1,
    CFG_DIAGONAL  = 2'd2
  } gaps_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RDWAIT,
    ST_CLEAR,
    ST_WALK,
    ST_SEL,
    ST_WAIT,
    ST_EVAL,
    ST_SCAN,
    ST_POP,
    ST_BLD_WR,
    ST_BLD_WAIT,
    ST_RESP
  } gaps_state_e;

  typedef struct packed {
    logic              open;
    logic              closed;
    logic [2:0]        parent;
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] f;
  } gaps_node_t;

  typedef struct packed {
    logic              eight_way;
    logic [STR_W-1:0]  straight;
    logic [DIAG_W-1:0] diagonal;
  } gaps_cfg_t;

  typedef struct packed {
    logic               found;
    logic [LEN_W-1:0]   length;
    logic [COORD_W-1:0] step_x;
    logic [COORD_W-1:0] step_y;
  } gaps_res_t;

endpackage

// ===== rtl/gaps_ram.sv =====
module gaps_ram #(
  parameter int DW = 1,
  parameter int AW = 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  localparam int Depth = 1 << AW;

  logic [DW-1:0] mem_q [Depth];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gaps_octile.sv =====
module gaps_octile #(
  parameter int XW = 6,
  parameter int YW = 6
) (
  input  logic                                clk_i,
  input  logic [XW-1:0]                       x_i,
  input  logic [YW-1:0]                       y_i,
  input  logic [XW-1:0]                       gx_i,
  input  logic [YW-1:0]                       gy_i,
  input  logic [gaps_pkg::STR_W-1:0]          straight_i,
  input  logic [gaps_pkg::DIAG_W-1:0]         diagonal_i,
  output logic [gaps_pkg::COST_W-1:0]         h_o
);

  localparam int MW = (XW > YW) ? XW : YW;
  localparam int PW = MW + gaps_pkg::DIAG_W + 1;

  logic [XW-1:0] dx;
  logic [YW-1:0] dy;
  logic [MW-1:0] dxm, dym;
  logic [MW-1:0] diag_n_q, str_n_q;
  logic [PW-1:0] h_q;

  always_comb begin
    dx  = (x_i > gx_i) ? (x_i - gx_i) : (gx_i - x_i);
    dy  = (y_i > gy_i) ? (y_i - gy_i) : (gy_i - y_i);
    dxm = MW'(dx);
    dym = MW'(dy);
  end

  // Stage one splits the distance into diagonal and straight step counts,
  // stage two weighs them.
  always_ff @(posedge clk_i) begin
    if (dxm < dym) begin
      diag_n_q <= dxm;
      str_n_q  <= dym - dxm;
    end else begin
      diag_n_q <= dym;
      str_n_q  <= dxm - dym;
    end
    h_q <= PW'(str_n_q) * PW'(straight_i) + PW'(diag_n_q) * PW'(diagonal_i);
  end

  assign h_o = gaps_pkg::COST_W'(h_q);

endmodule

// ===== rtl/gaps_search.sv =====
module gaps_search #(
  parameter int GRID_W = gaps_pkg::GRID_W_DEF,
  parameter int GRID_H = gaps_pkg::GRID_H_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [gaps_pkg::COORD_W-1:0]       cell_x_i,
  input  logic [gaps_pkg::COORD_W-1:0]       cell_y_i,
  input  logic                               passable_i,
  input  logic [gaps_pkg::COORD_W-1:0]       goal_x_i,
  input  logic [gaps_pkg::COORD_W-1:0]       goal_y_i,
  input  logic [gaps_pkg::STEP_W-1:0]        step_index_i,
  input  gaps_pkg::gaps_cfg_t                cfg_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output gaps_pkg::gaps_res_t                res_o
);

  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);
  localparam int AW     = XW + YW;
  localparam int NCELLS = GRID_W * GRID_H;
  localparam int SW     = $clog2(NCELLS + 1);
  localparam int CW     = gaps_pkg::COST_W;
  localparam int NW     = $bits(gaps_pkg::gaps_node_t);

  gaps_pkg::gaps_state_e state_q, state_d;
  gaps_pkg::gaps_res_t   res_q, res_d;
  gaps_pkg::gaps_node_t  nw_q, nw_d, best_node_q, best_node_d;
  gaps_pkg::gaps_node_t  node_rdata, node_wdata;

  logic [XW-1:0] sx_q, sx_d, gx_q, gx_d, cx_q, cx_d;
  logic [YW-1:0] sy_q, sy_d, gy_q, gy_d, cy_q, cy_d;
  logic [CW-1:0] gcur_q, gcur_d, g_q, g_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [3:0]    wcnt_q, wcnt_d, dir_q, dir_d;
  logic [7:0]    wk_q, wk_d;
  logic [SW-1:0] open_size_q, open_size_d, scan_q, scan_d;
  logic          s1_vld_q, s1_vld_d, s2_vld_q, s2_vld_d;
  logic [SW-1:0] s1_pos_q, s1_pos_d, s2_pos_q, s2_pos_d, best_pos_q, best_pos_d;
  logic [AW-1:0] s2_ent_q, s2_ent_d, best_ent_q, best_ent_d;
  logic [SW-1:0] pop_rd_q, pop_rd_d;
  logic          pend_q, pend_d, rd_hit_q, rd_hit_d;
  logic [AW-1:0] pend_a_q, pend_a_d, t_q, t_d;
  logic [SW-1:0] path_cnt_q, path_cnt_d, path_size_q, path_size_d;

  logic          walk_we, walk_wdata, walk_rdata;
  logic [AW-1:0] walk_waddr, walk_raddr;
  logic          node_we;
  logic [AW-1:0] node_waddr, node_raddr;
  logic          open_we;
  logic [AW-1:0] open_waddr, open_wdata, open_raddr, open_rdata;
  logic          path_we;
  logic [AW-1:0] path_waddr, path_wdata, path_raddr, path_rdata;

  logic [XW-1:0] nx_a [8];
  logic [YW-1:0] ny_a [8];
  logic [7:0]    inb;
  logic [2:0]    k;
  logic [CW-1:0] h;
  logic [CW:0]   f_sum, g_sum;
  logic [CW-1:0] f_sat;
  logic [SW-1:0] cnt_next;
  logic [2:0]    par;
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;
  logic          in_range, nb_ok;

  gaps_ram #(.DW(1), .AW(AW)) u_walk_ram (
    .clk_i, .we_i(walk_we), .waddr_i(walk_waddr), .wdata_i(walk_wdata),
    .raddr_i(walk_raddr), .rdata_o(walk_rdata)
  );

  gaps_ram #(.DW(NW), .AW(AW)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata)
  );

  gaps_ram #(.DW(AW), .AW(AW)) u_open_ram (
    .clk_i, .we_i(open_we), .waddr_i(open_waddr), .wdata_i(open_wdata),
    .raddr_i(open_raddr), .rdata_o(open_rdata)
  );

  gaps_ram #(.DW(AW), .AW(AW)) u_path_ram (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .raddr_i(path_raddr), .rdata_o(path_rdata)
  );

  assign k = dir_q[2:0];

  gaps_octile #(.XW(XW), .YW(YW)) u_octile (
    .clk_i,
    .x_i       (nx_a[k]),
    .y_i       (ny_a[k]),
    .gx_i      (gx_q),
    .gy_i      (gy_q),
    .straight_i(cfg_i.straight),
    .diagonal_i(cfg_i.diagonal),
    .h_o       (h)
  );

  // Neighbor coordinates and grid bounds of the current cell.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nx_a[i] = cx_q;
      ny_a[i] = cy_q;
      inb[i]  = 1'b1;
      if (gaps_pkg::DX_NEG[i]) begin
        inb[i]  = inb[i] & (cx_q != '0);
        nx_a[i] = cx_q - XW'(1);
      end
      if (gaps_pkg::DX_POS[i]) begin
        inb[i]  = inb[i] & (cx_q != XW'(GRID_W - 1));
        nx_a[i] = cx_q + XW'(1);
      end
      if (gaps_pkg::DY_NEG[i]) begin
        inb[i]  = inb[i] & (cy_q != '0);
        ny_a[i] = cy_q - YW'(1);
      end
      if (gaps_pkg::DY_POS[i]) begin
        inb[i]  = inb[i] & (cy_q != YW'(GRID_H - 1));
        ny_a[i] = cy_q + YW'(1);
      end
    end
  end

  assign f_sum = {1'b0, g_q} + {1'b0, h};
  assign f_sat = f_sum[CW] ? gaps_pkg::COST_CAP : f_sum[CW-1:0];
  assign g_sum = {1'b0, gcur_q} +
                 (gaps_pkg::DIAG[k] ? (CW + 1)'(cfg_i.diagonal) : (CW + 1)'(cfg_i.straight));
  assign cnt_next = path_cnt_q + SW'(1);
  assign par = node_rdata.parent;
  assign tx  = t_q[XW-1:0];
  assign ty  = t_q[AW-1:XW];

  assign in_range = (16'(cell_x_i) < 16'(GRID_W)) && (16'(cell_y_i) < 16'(GRID_H));

  always_comb begin
    nb_ok = inb[k];
    if (gaps_pkg::DIAG[k]) begin
      nb_ok = nb_ok && cfg_i.eight_way &&
              wk_q[gaps_pkg::DX_NEG[k] ? gaps_pkg::DIR_LEFT : gaps_pkg::DIR_RIGHT] &&
              wk_q[gaps_pkg::DY_NEG[k] ? gaps_pkg::DIR_UP : gaps_pkg::DIR_DOWN];
    end
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    nw_d        = nw_q;
    best_node_d = best_node_q;
    sx_d = sx_q; sy_d = sy_q; gx_d = gx_q; gy_d = gy_q; cx_d = cx_q; cy_d = cy_q;
    gcur_d      = gcur_q;
    g_d         = g_q;
    clr_d       = clr_q;
    wcnt_d      = wcnt_q;
    dir_d       = dir_q;
    wk_d        = wk_q;
    open_size_d = open_size_q;
    scan_d      = scan_q;
    s1_vld_d    = 1'b0;
    s1_pos_d    = s1_pos_q;
    s2_vld_d    = 1'b0;
    s2_pos_d    = s2_pos_q;
    s2_ent_d    = s2_ent_q;
    best_pos_d  = best_pos_q;
    best_ent_d  = best_ent_q;
    pop_rd_d    = pop_rd_q;
    pend_d      = pend_q;
    pend_a_d    = pend_a_q;
    rd_hit_d    = rd_hit_q;
    t_d         = t_q;
    path_cnt_d  = path_cnt_q;
    path_size_d = path_size_q;

    walk_we    = 1'b0;
    walk_waddr = '0;
    walk_wdata = 1'b0;
    walk_raddr = {ny_a[wcnt_q[2:0]], nx_a[wcnt_q[2:0]]};
    node_we    = 1'b0;
    node_waddr = {ny_a[k], nx_a[k]};
    node_wdata = nw_q;
    node_raddr = {ny_a[k], nx_a[k]};
    open_we    = 1'b0;
    open_waddr = open_size_q[AW-1:0];
    open_wdata = {ny_a[k], nx_a[k]};
    open_raddr = scan_q[AW-1:0];
    path_we    = 1'b0;
    path_waddr = path_cnt_q[AW-1:0];
    path_wdata = t_q;
    path_raddr = AW'(path_size_q - SW'(1) - SW'(step_index_i));
    res_valid_o = 1'b0;

    case (state_q)
      gaps_pkg::ST_INIT: begin
        walk_we    = 1'b1;
        walk_waddr = clr_q;
        clr_d      = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = gaps_pkg::ST_IDLE;
        end
      end

      gaps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = gaps_pkg::ST_RESP;
          case (gaps_pkg::gaps_op_e'(operation_i))
            gaps_pkg::OP_WRITE: begin
              walk_we    = in_range;
              walk_waddr = {YW'(cell_y_i), XW'(cell_x_i)};
              walk_wdata = passable_i;
            end
            gaps_pkg::OP_SEARCH: begin
              path_size_d = '0;
              open_size_d = '0;
              sx_d   = XW'(cell_x_i);
              sy_d   = YW'(cell_y_i);
              gx_d   = XW'(goal_x_i);
              gy_d   = YW'(goal_y_i);
              cx_d   = XW'(cell_x_i);
              cy_d   = YW'(cell_y_i);
              gcur_d = '0;
              clr_d  = '0;
              if (in_range && (16'(goal_x_i) < 16'(GRID_W)) &&
                  (16'(goal_y_i) < 16'(GRID_H)) &&
                  !((cell_x_i == goal_x_i) && (cell_y_i == goal_y_i))) begin
                state_d = gaps_pkg::ST_CLEAR;
              end
            end
            gaps_pkg::OP_READ: begin
              res_d.found  = (path_size_q != '0);
              res_d.length = gaps_pkg::LEN_W'(path_size_q);
              rd_hit_d     = (32'(step_index_i) < 32'(path_size_q));
              state_d      = gaps_pkg::ST_RDWAIT;
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end

      gaps_pkg::ST_RDWAIT: begin
        if (rd_hit_q) begin
          res_d.step_x = gaps_pkg::COORD_W'(path_rdata[XW-1:0]);
          res_d.step_y = gaps_pkg::COORD_W'(path_rdata[AW-1:XW]);
        end
        state_d = gaps_pkg::ST_RESP;
      end

      gaps_pkg::ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = '0;
        if (clr_q == {sy_q, sx_q}) begin
          node_wdata.open   = 1'b1;
          node_wdata.closed = 1'b1;
        end
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          wcnt_d  = '0;
          state_d = gaps_pkg::ST_WALK;
        end
      end

      // Fetch the walkable bits of all eight neighbors, one per cycle.
      gaps_pkg::ST_WALK: begin
        if (wcnt_q != 4'd0) begin
          wk_d[3'(wcnt_q - 4'd1)] = walk_rdata & inb[3'(wcnt_q - 4'd1)];
        end
        wcnt_d = wcnt_q + 4'd1;
        if (wcnt_q == 4'd8) begin
          dir_d   = '0;
          state_d = gaps_pkg::ST_SEL;
        end
      end

      gaps_pkg::ST_SEL: begin
        if (dir_q == 4'd8) begin
          if (open_size_q == '0) begin
            res_d   = '0;
            state_d = gaps_pkg::ST_RESP;
          end else begin
            scan_d  = '0;
            state_d = gaps_pkg::ST_SCAN;
          end
        end else if (nb_ok) begin
          state_d = gaps_pkg::ST_WAIT;
        end else begin
          dir_d = dir_q + 4'd1;
        end
      end

      gaps_pkg::ST_WAIT: begin
        nw_d    = node_rdata;
        g_d     = g_sum[CW] ? gaps_pkg::COST_CAP : g_sum[CW-1:0];
        state_d = gaps_pkg::ST_EVAL;
      end

      gaps_pkg::ST_EVAL: begin
        if (!nw_q.closed) begin
          if (!wk_q[k]) begin
            node_we           = 1'b1;
            node_wdata.open   = 1'b1;
            node_wdata.closed = 1'b1;
          end else if (!nw_q.open) begin
            node_we           = 1'b1;
            node_wdata.open   = 1'b1;
            node_wdata.parent = k;
            node_wdata.g      = g_q;
            node_wdata.f      = f_sat;
            open_we           = 1'b1;
            open_size_d       = open_size_q + SW'(1);
          end else if (g_q < nw_q.g) begin
            node_we           = 1'b1;
            node_wdata.parent = k;
            node_wdata.g      = g_q;
            node_wdata.f      = f_sat;
          end
        end
        dir_d   = dir_q + 4'd1;
        state_d = gaps_pkg::ST_SEL;
      end

      // Three-stage walk over the open list: entry, node word, compare.
      gaps_pkg::ST_SCAN: begin
        open_raddr = scan_q[AW-1:0];
        node_raddr = open_rdata;
        if (scan_q < open_size_q) begin
          s1_vld_d = 1'b1;
          s1_pos_d = scan_q;
          scan_d   = scan_q + SW'(1);
        end
        if (s1_vld_q) begin
          s2_vld_d = 1'b1;
          s2_pos_d = s1_pos_q;
          s2_ent_d = open_rdata;
        end
        if (s2_vld_q && ((s2_pos_q == '0) || (node_rdata.f < best_node_q.f))) begin
          best_pos_d  = s2_pos_q;
          best_ent_d  = s2_ent_q;
          best_node_d = node_rdata;
        end
        if ((scan_q >= open_size_q) && !s1_vld_q && !s2_vld_q) begin
          pop_rd_d = best_pos_q + SW'(1);
          pend_d   = 1'b0;
          state_d  = gaps_pkg::ST_POP;
        end
      end

      // Close the chosen node and shift the later entries down by one.
      gaps_pkg::ST_POP: begin
        node_we           = 1'b1;
        node_waddr        = best_ent_q;
        node_wdata        = best_node_q;
        node_wdata.closed = 1'b1;
        open_raddr        = pop_rd_q[AW-1:0];
        open_we           = pend_q;
        open_waddr        = pend_a_q;
        open_wdata        = open_rdata;
        if (pop_rd_q < open_size_q) begin
          pend_d   = 1'b1;
          pend_a_d = AW'(pop_rd_q - SW'(1));
          pop_rd_d = pop_rd_q + SW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            open_size_d = open_size_q - SW'(1);
            cx_d        = best_ent_q[XW-1:0];
            cy_d        = best_ent_q[AW-1:XW];
            gcur_d      = best_node_q.g;
            if (best_ent_q == {gy_q, gx_q}) begin
              t_d        = best_ent_q;
              path_cnt_d = '0;
              state_d    = gaps_pkg::ST_BLD_WR;
            end else begin
              wcnt_d  = '0;
              state_d = gaps_pkg::ST_WALK;
            end
          end
        end
      end

      // The path is stored goal first; reads index it from the far end.
      gaps_pkg::ST_BLD_WR: begin
        path_we    = 1'b1;
        node_raddr = t_q;
        path_cnt_d = cnt_next;
        if ((t_q == {sy_q, sx_q}) || (32'(cnt_next) >= NCELLS)) begin
          path_size_d  = cnt_next;
          res_d        = '0;
          res_d.found  = 1'b1;
          res_d.length = gaps_pkg::LEN_W'(cnt_next);
          state_d      = gaps_pkg::ST_RESP;
        end else begin
          state_d = gaps_pkg::ST_BLD_WAIT;
        end
      end

      gaps_pkg::ST_BLD_WAIT: begin
        t_d     = t_q;
        state_d = gaps_pkg::ST_BLD_WR;
        if ((gaps_pkg::DX_NEG[par] && (tx == XW'(GRID_W - 1))) ||
            (gaps_pkg::DX_POS[par] && (tx == '0)) ||
            (gaps_pkg::DY_NEG[par] && (ty == YW'(GRID_H - 1))) ||
            (gaps_pkg::DY_POS[par] && (ty == '0))) begin
          path_size_d  = path_cnt_q;
          res_d        = '0;
          res_d.found  = 1'b1;
          res_d.length = gaps_pkg::LEN_W'(path_cnt_q);
          state_d      = gaps_pkg::ST_RESP;
        end else begin
          if (gaps_pkg::DX_NEG[par]) t_d[XW-1:0] = tx + XW'(1);
          if (gaps_pkg::DX_POS[par]) t_d[XW-1:0] = tx - XW'(1);
          if (gaps_pkg::DY_NEG[par]) t_d[AW-1:XW] = ty + YW'(1);
          if (gaps_pkg::DY_POS[par]) t_d[AW-1:XW] = ty - YW'(1);
        end
      end

      gaps_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = gaps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = gaps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gaps_pkg::ST_INIT;
      clr_q       <= '0;
      open_size_q <= '0;
      path_size_q <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      open_size_q <= open_size_d;
      path_size_q <= path_size_d;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s2_vld_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    nw_q        <= nw_d;
    best_node_q <= best_node_d;
    sx_q <= sx_d; sy_q <= sy_d; gx_q <= gx_d; gy_q <= gy_d; cx_q <= cx_d; cy_q <= cy_d;
    gcur_q      <= gcur_d;
    g_q         <= g_d;
    wcnt_q      <= wcnt_d;
    dir_q       <= dir_d;
    wk_q        <= wk_d;
    scan_q      <= scan_d;
    s1_pos_q    <= s1_pos_d;
    s2_pos_q    <= s2_pos_d;
    s2_ent_q    <= s2_ent_d;
    best_pos_q  <= best_pos_d;
    best_ent_q  <= best_ent_d;
    pop_rd_q    <= pop_rd_d;
    pend_a_q    <= pend_a_d;
    rd_hit_q    <= rd_hit_d;
    t_q         <= t_d;
    path_cnt_q  <= path_cnt_d;
  end

  assign in_stall_o = (state_q != gaps_pkg::ST_IDLE);
  assign res_o      = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gaps_pkg::ST_EVAL |-> $past(state_q) == gaps_pkg::ST_WAIT)
    else $error("neighbor evaluated without a node read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gaps_pkg::ST_POP && state_d != gaps_pkg::ST_POP)
      |=> open_size_q == $past(open_size_q) - SW'(1))
    else $error("open list did not shrink by one on removal");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gaps_pkg::ST_EVAL && node_we) |-> node_wdata.open)
    else $error("evaluated neighbor written without open mark");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gaps_pkg::ST_BLD_WR |-> 32'(path_cnt_q) < NCELLS)
    else $error("path buffer overrun");

endmodule

// ===== rtl/grid_astar_path_search_unit.sv =====
// Grid A* path search unit.
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
// write one grid cell, search a path between two cells, or read one step of
// the last path found. Each accepted operation yields exactly one result
// transfer on the output channel (out_valid_o / out_stall_i).
// Configuration writes (cfg_valid_i / cfg_ready_o) set the move mode and the
// straight and diagonal step costs; they are taken only while no operation
// is in flight.
// A search first clears the node memory, then for every node it expands
// fetches neighbor walkability, reads and evaluates each reachable
// neighbor and skips the other directions, scans and compacts the open
// list, then records the path cell by cell. The node memory has a single
// read port.
// After reset the grid memory is swept to all blocked, with in_stall_o
// high throughout.
// One finished result is held in the output register while out_stall_i is
// high; a new operation is accepted meanwhile and waits for that slot.
module grid_astar_path_search_unit #(
  parameter int GRID_W = gaps_pkg::GRID_W_DEF,
  parameter int GRID_H = gaps_pkg::GRID_H_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           operation_i,
  input  logic [gaps_pkg::COORD_W-1:0]         cell_x_i,
  input  logic [gaps_pkg::COORD_W-1:0]         cell_y_i,
  input  logic                                 passable_i,
  input  logic [gaps_pkg::COORD_W-1:0]         goal_x_i,
  input  logic [gaps_pkg::COORD_W-1:0]         goal_y_i,
  input  logic [gaps_pkg::STEP_W-1:0]          step_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 path_found_o,
  output logic [gaps_pkg::LEN_W-1:0]           path_length_o,
  output logic [gaps_pkg::COORD_W-1:0]         step_x_o,
  output logic [gaps_pkg::COORD_W-1:0]         step_y_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gaps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gaps_pkg::DIAG_W-1:0]          cfg_data_i
);

  gaps_pkg::gaps_cfg_t cfg_q, cfg_d;
  gaps_pkg::gaps_res_t res, out_q;
  logic                res_valid, res_ready;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (gaps_pkg::gaps_cfg_idx_e'(cfg_index_i))
        gaps_pkg::CFG_EIGHT_WAY: cfg_d.eight_way = cfg_data_i[0];
        gaps_pkg::CFG_STRAIGHT:  cfg_d.straight  = cfg_data_i[gaps_pkg::STR_W-1:0];
        gaps_pkg::CFG_DIAGONAL:  cfg_d.diagonal  = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eight_way <= gaps_pkg::EIGHT_WAY_RST;
      cfg_q.straight  <= gaps_pkg::STRAIGHT_RST;
      cfg_q.diagonal  <= gaps_pkg::DIAGONAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Settings change only while the search core is idle and no result waits.
  assign cfg_ready_o = !in_stall_o && !in_valid_i && !out_valid_q;

  gaps_search #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_search (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .cell_x_i,
    .cell_y_i,
    .passable_i,
    .goal_x_i,
    .goal_y_i,
    .step_index_i,
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // The output slot frees up in the same cycle its transfer completes.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign path_found_o  = out_q.found;
  assign path_length_o = out_q.length;
  assign step_x_o      = out_q.step_x;
  assign step_y_o      = out_q.step_y;

endmodule

// ===== bench/tb_grid_astar_path_search_unit.sv =====
`timescale 1ns / 100ps

module tb_grid_astar_path_search_unit;

  localparam int GW = 64;
  localparam int GH = 64;
  localparam int NC = GW * GH;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    logic                         found;
    logic [gaps_pkg::LEN_W-1:0]   length;
    logic [gaps_pkg::COORD_W-1:0] sx;
    logic [gaps_pkg::COORD_W-1:0] sy;
  } route_result_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] operation_i;
  logic [gaps_pkg::COORD_W-1:0] cell_x_i;
  logic [gaps_pkg::COORD_W-1:0] cell_y_i;
  logic passable_i;
  logic [gaps_pkg::COORD_W-1:0] goal_x_i;
  logic [gaps_pkg::COORD_W-1:0] goal_y_i;
  logic [gaps_pkg::STEP_W-1:0] step_index_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic path_found_o;
  logic [gaps_pkg::LEN_W-1:0] path_length_o;
  logic [gaps_pkg::COORD_W-1:0] step_x_o;
  logic [gaps_pkg::COORD_W-1:0] step_y_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [gaps_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [gaps_pkg::DIAG_W-1:0] cfg_data_i;

  grid_astar_path_search_unit uut (.*);

  // Predictor state.
  bit              m_eight;
  int unsigned     m_straight;
  int unsigned     m_diagonal;
  bit              m_walk[NC];
  bit              m_open[NC];
  bit              m_closed[NC];
  int unsigned     m_gcost[NC];
  int unsigned     m_fcost[NC];
  int              m_parent[NC];
  int unsigned     m_olist[NC];
  int              m_osize;
  int unsigned     m_path[NC];
  int              m_psize;
  const int        MDX[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
  const int        MDY[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

  route_result_t route_results_q[$];
  int  error_count = 0;
  bit  sender_steady;
  bit  receiver_steady;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  longint cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned cap_cost(longint unsigned v);
    return (v > 64'(gaps_pkg::COST_CAP)) ? int'(gaps_pkg::COST_CAP) : int'(v);
  endfunction

  function automatic int unsigned octile_cost(int x1, int y1, int x2, int y2);
    longint unsigned dx, dy, d;
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    d = (dx < dy) ? dx : dy;
    return cap_cost((dx + dy - 2 * d) * m_straight + d * m_diagonal);
  endfunction

  task automatic trace_back(int unsigned start, int unsigned goal);
    int unsigned t;
    int n;
    int px, py;
    int unsigned s;
    t = goal;
    n = 0;
    m_path[n] = t;
    n = n + 1;
    while (t != start && n < NC) begin
      px = int'(t % GW) - MDX[m_parent[t]];
      py = int'(t / GW) - MDY[m_parent[t]];
      if (px < 0 || px >= GW || py < 0 || py >= GH) break;
      t = py * GW + px;
      m_path[n] = t;
      n = n + 1;
    end
    for (int i = 0; i < n / 2; i++) begin
      s = m_path[i];
      m_path[i] = m_path[n - 1 - i];
      m_path[n - 1 - i] = s;
    end
    m_psize = n;
  endtask

  task automatic search_route(int sx, int sy, int gx, int gy);
    int unsigned start, goal, cur, n, g;
    int cx, cy, nx, ny, best;
    bit diag;
    m_psize = 0;
    m_osize = 0;
    if (sx == gx && sy == gy) return;
    for (int i = 0; i < NC; i++) begin
      m_open[i] = 0;
      m_closed[i] = 0;
    end
    start = sy * GW + sx;
    goal = gy * GW + gx;
    m_open[start] = 1;
    m_closed[start] = 1;
    m_gcost[start] = 0;
    m_fcost[start] = octile_cost(sx, sy, gx, gy);
    cur = start;
    forever begin
      cx = cur % GW;
      cy = cur / GW;
      for (int k = 0; k < 8; k++) begin
        nx = cx + MDX[k];
        ny = cy + MDY[k];
        diag = (MDX[k] != 0) && (MDY[k] != 0);
        if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
        // Diagonal moves may not cut past a blocked straight neighbor.
        if (diag && (!m_eight || !m_walk[cy * GW + nx] || !m_walk[ny * GW + cx])) continue;
        n = ny * GW + nx;
        if (m_closed[n]) continue;
        if (!m_walk[n]) begin
          m_open[n] = 1;
          m_closed[n] = 1;
          continue;
        end
        g = cap_cost(longint'(m_gcost[cur]) + (diag ? m_diagonal : m_straight));
        if (!m_open[n]) begin
          m_open[n] = 1;
          m_parent[n] = k;
          m_gcost[n] = g;
          m_fcost[n] = cap_cost(longint'(g) + octile_cost(nx, ny, gx, gy));
          if (m_osize < NC) begin
            m_olist[m_osize] = n;
            m_osize = m_osize + 1;
          end
        end else if (g < m_gcost[n]) begin
          m_gcost[n] = g;
          m_fcost[n] = cap_cost(longint'(g) + octile_cost(nx, ny, gx, gy));
          m_parent[n] = k;
        end
      end
      if (m_osize == 0) return;
      best = 0;
      for (int p = 1; p < m_osize; p++)
        if (m_fcost[m_olist[p]] < m_fcost[m_olist[best]]) best = p;
      cur = m_olist[best];
      for (int p = best; p < m_osize - 1; p++) m_olist[p] = m_olist[p + 1];
      m_osize--;
      m_closed[cur] = 1;
      if (cur == goal) begin
        trace_back(start, goal);
        return;
      end
    end
  endtask

  task automatic compute_route_result(logic [1:0] op, int cx, int cy, bit pass, int gx, int gy,
                                      int step);
    route_result_t r;
    r = '{found: 0, length: '0, sx: '0, sy: '0};
    case (op)
      gaps_pkg::OP_WRITE: begin
        m_walk[cy * GW + cx] = pass;
      end
      gaps_pkg::OP_SEARCH: begin
        search_route(cx, cy, gx, gy);
        r.found = m_psize != 0;
        r.length = gaps_pkg::LEN_W'(m_psize);
      end
      gaps_pkg::OP_READ: begin
        r.found = m_psize != 0;
        r.length = gaps_pkg::LEN_W'(m_psize);
        if (step < m_psize) begin
          r.sx = gaps_pkg::COORD_W'(m_path[step] % GW);
          r.sy = gaps_pkg::COORD_W'(m_path[step] / GW);
        end
      end
      default: ;
    endcase
    route_results_q.insert(route_results_q.size(), r);
  endtask

  // Long receiver hold, counted here once a test asks for it.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side: checks every transfer and draws its own stall pattern.
  int stall_left = 0;
  always @(posedge clk_i) begin
    route_result_t e;
    if (out_valid_o && !out_stall_i) begin
      if (route_results_q.size() == 0) begin
        $error("unexpected result transfer");
        error_count++;
      end else begin
        e = route_results_q.pop_front();
        if (path_found_o !== e.found) begin
          $error("path_found expected %0d actual %0d", e.found, path_found_o);
          error_count++;
        end
        if (path_length_o !== e.length) begin
          $error("path_length expected %0d actual %0d", e.length, path_length_o);
          error_count++;
        end
        if (step_x_o !== e.sx) begin
          $error("step_x expected %0d actual %0d", e.sx, step_x_o);
          error_count++;
        end
        if (step_y_o !== e.sy) begin
          $error("step_y expected %0d actual %0d", e.sy, step_y_o);
          error_count++;
        end
      end
      stall_left = receiver_steady ? 0 : $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_op(logic [1:0] op, int cx, int cy, bit pass, int gx, int gy, int step);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    cell_x_i <= gaps_pkg::COORD_W'(cx);
    cell_y_i <= gaps_pkg::COORD_W'(cy);
    passable_i <= pass;
    goal_x_i <= gaps_pkg::COORD_W'(gx);
    goal_y_i <= gaps_pkg::COORD_W'(gy);
    step_index_i <= gaps_pkg::STEP_W'(step);
    do @(posedge clk_i); while (in_stall_o);
    compute_route_result(op, cx & 63, cy & 63, pass, gx & 63, gy & 63, step & 'hfff);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (route_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(gaps_pkg::gaps_cfg_idx_e idx, int value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= gaps_pkg::DIAG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      gaps_pkg::CFG_EIGHT_WAY: m_eight = value[0];
      gaps_pkg::CFG_STRAIGHT:  m_straight = value & 'h3ff;
      default:                 m_diagonal = value & 'h7ff;
    endcase
  endtask

  task automatic set_costs(bit eight, int straight, int diagonal);
    write_register(gaps_pkg::CFG_EIGHT_WAY, eight);
    write_register(gaps_pkg::CFG_STRAIGHT, straight);
    write_register(gaps_pkg::CFG_DIAGONAL, diagonal);
  endtask

  task automatic test_directed();
    // A fully blocked grid gives no route from the start cell.
    send_op(gaps_pkg::OP_SEARCH, 0, 0, 0, 1, 0, 0);
    send_op(gaps_pkg::OP_WRITE, 0, 0, 1, 0, 0, 0);
    send_op(gaps_pkg::OP_WRITE, 1, 0, 1, 0, 0, 0);
    send_op(gaps_pkg::OP_WRITE, 1, 1, 1, 0, 0, 0);
    send_op(gaps_pkg::OP_WRITE, 2, 1, 1, 0, 0, 0);
    send_op(gaps_pkg::OP_WRITE, 63, 63, 1, 0, 0, 0);
    send_op(gaps_pkg::OP_WRITE, 63, 63, 0, 63, 63, 4095);
    send_op(gaps_pkg::OP_SEARCH, 0, 0, 0, 2, 1, 0);
    send_op(gaps_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    send_op(gaps_pkg::OP_READ, 0, 0, 0, 0, 0, 2);
    send_op(gaps_pkg::OP_READ, 63, 63, 1, 63, 63, 4095);
    send_op(OP_UNKNOWN, 63, 63, 1, 63, 63, 4095);
    // The start cell itself is blocked, yet the search still runs.
    send_op(gaps_pkg::OP_SEARCH, 2, 0, 1, 0, 0, 0);
    send_op(gaps_pkg::OP_READ, 0, 0, 0, 0, 0, 1);
    send_op(gaps_pkg::OP_SEARCH, 1, 1, 0, 1, 1, 0);
    send_op(gaps_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    send_op(gaps_pkg::OP_SEARCH, 63, 63, 1, 0, 0, 0);
    send_op(gaps_pkg::OP_SEARCH, 0, 0, 0, 63, 63, 0);
  endtask

  task automatic random_ops(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45)
        send_op(gaps_pkg::OP_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                $urandom_range(0, 9) < 7, $urandom, $urandom, $urandom);
      else if (kind < 52)
        send_op(gaps_pkg::OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), 0,
                $urandom, $urandom, $urandom);
      else if (kind < 68)
        send_op(gaps_pkg::OP_SEARCH, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      else if (kind < 72)
        send_op(gaps_pkg::OP_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      else if (kind < 95)
        send_op(gaps_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 15));
      else
        send_op(OP_UNKNOWN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_settings();
    set_costs(1'b0, 16, 22);
    random_ops(20);
    set_costs(1'b1, 1, 1447);
    random_ops(20);
    set_costs(1'b1, 1023, 1);
    random_ops(20);
    set_costs(1'b1, 16, 22);
    random_ops(15);
  endtask

  task automatic test_backpressure();
    // The receiver holds off long enough for the block to fill and stall.
    hold_req = hold_req + 1;
    sender_steady = 1;
    for (int i = 0; i < 8; i++)
      send_op(gaps_pkg::OP_READ, 0, 0, 0, 0, 0, i);
    sender_steady = 0;
    wait_drained();
    receiver_steady = 1;
    sender_steady = 1;
    random_ops(10);
    receiver_steady = 0;
    sender_steady = 0;
  endtask

  initial begin
    m_eight = gaps_pkg::EIGHT_WAY_RST;
    m_straight = gaps_pkg::STRAIGHT_RST;
    m_diagonal = gaps_pkg::DIAGONAL_RST;
    m_psize = 0;
    m_osize = 0;
    for (int i = 0; i < NC; i++) m_walk[i] = 0;
    sender_steady = 0;
    receiver_steady = 0;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = gaps_pkg::OP_WRITE;
    cell_x_i = '0;
    cell_y_i = '0;
    passable_i = 1'b0;
    goal_x_i = '0;
    goal_y_i = '0;
    step_index_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gaps_pkg::CFG_EIGHT_WAY;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_settings();

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && route_results_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
